@@ hdl/vgd_pkg.sv @@
// Shared types and constants for the voxel-grid downsampler.
package vgd_pkg;

	localparam int MAX_VOXELS_DEF = 4096;
	localparam int HASH_SLOTS_DEF = 8192;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [23:0] INV_RESET = 24'd65536;

	// configuration register indexes
	localparam logic CFG_INV  = 1'b0;
	localparam logic CFG_MODE = 1'b1;

	// item actions
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// result status codes
	localparam logic [2:0] ST_MERGED = 3'd0;
	localparam logic [2:0] ST_NEW    = 3'd1;
	localparam logic [2:0] ST_DROP   = 3'd2;
	localparam logic [2:0] ST_RESULT = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	// spatial hash multipliers
	localparam logic signed [27:0] HASH_KX = 28'sd73856093;
	localparam logic signed [27:0] HASH_KY = 28'sd19349663;
	localparam logic signed [27:0] HASH_KZ = 28'sd83492791;

	typedef struct packed {
		logic               action;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [15:0]        intensity_in;
		logic [47:0]        stamp_in;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
		logic [15:0]        intensity_out;
		logic [47:0]        stamp_out;
		logic               last;
	} rsp_t;

endpackage

@@ hdl/voxel_grid_downsample_top.sv @@
// Voxel-grid downsampler: sequencer, voxel table and hash index.
//
//  channel   signals                          accepted when
//  item in   start, busy, cmd                 start & !busy
//  result    done, rsp                        done (one cycle, no backpressure)
//  config    cfg_valid, cfg_ready, cfg_index  cfg_valid & cfg_ready
//
// Add item: key and hash products on one shared multiplier; the slot is the low
// hash bits (HASH_SLOTS is a power of two). Then states PRD, PHV, PVK per probe of
// an occupied slot, PRD and PHV on the empty slot, and ADD to write the entry.
// Read item: RRD, RWT, OUT in latest mode; centroid mode adds four divides.
// A read of an empty table answers the cycle after start, busy stays low.
// After reset and after the last voxel is read the hash index is swept clear,
// with busy high. Results cannot be stalled.
module voxel_grid_downsample_top #(
	parameter int MAX_VOXELS = vgd_pkg::MAX_VOXELS_DEF,
	parameter int HASH_SLOTS = vgd_pkg::HASH_SLOTS_DEF,
	parameter int COUNT_BITS = vgd_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  vgd_pkg::cmd_t cmd,
	output logic          done,
	output vgd_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [23:0]   cfg_data
);
	import vgd_pkg::*;

	localparam int VI_W   = $clog2(MAX_VOXELS);
	localparam int UW     = $clog2(MAX_VOXELS + 1);
	localparam int HS_W   = $clog2(HASH_SLOTS);
	localparam int PW     = $clog2(HASH_SLOTS + 1);
	localparam int SUM_W  = 32 + COUNT_BITS;
	localparam int ISUM_W = 16 + COUNT_BITS;
	localparam int DW     = SUM_W;
	localparam int DVW    = COUNT_BITS;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_KEY  = 4'd2;
	localparam logic [3:0] S_HASH = 4'd3;
	localparam logic [3:0] S_PRD  = 4'd5;
	localparam logic [3:0] S_PHV  = 4'd6;
	localparam logic [3:0] S_PVK  = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;
	localparam logic [3:0] S_RRD  = 4'd9;
	localparam logic [3:0] S_RWT  = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	typedef struct packed {
		logic [23:0]       kx;
		logic [23:0]       ky;
		logic [23:0]       kz;
		logic [SUM_W-1:0]  sx;
		logic [SUM_W-1:0]  sy;
		logic [SUM_W-1:0]  sz;
		logic [ISUM_W-1:0] iacc;
		logic [47:0]       stamp;
		logic [COUNT_BITS-1:0] cnt;
	} vox_t;

	typedef struct packed {
		logic            vld;
		logic [VI_W-1:0] idx;
	} slot_t;

	// storage
	vox_t  vox_mem [MAX_VOXELS];
	slot_t hash_mem [HASH_SLOTS];

	logic [3:0]      state_q;
	logic [1:0]      step_q;
	cmd_t            cmd_q;
	logic [23:0]     inv_q;
	logic            mode_q;
	logic [23:0]     kx_q, ky_q, kz_q;
	logic [31:0]     h_q;
	logic [HS_W-1:0] slot_q;
	logic [PW-1:0]   probe_q;
	logic [VI_W-1:0] vidx_q;
	logic            found_q;
	logic            empty_q;
	logic [UW-1:0]   used_q;
	logic [UW-1:0]   rp_q;
	logic [HS_W-1:0] clr_q;
	logic [1:0]      axis_q;
	logic [31:0]     rx_q, ry_q, rz_q;
	logic [15:0]     ri_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic signed [32:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [60:0] prod_s1;

	slot_t hrd_q;
	vox_t  vrd_q;

	// memory ports
	logic            h_we;
	logic [HS_W-1:0] h_wa;
	slot_t           h_wd;
	logic            v_we;
	logic [VI_W-1:0] v_wa;
	vox_t            v_wd;
	logic            v_re;
	logic [VI_W-1:0] v_ra;

	// divider
	logic           div_start;
	logic [DW-1:0]  div_dvd;
	logic [DVW-1:0] div_dvs;
	logic           div_done;
	logic [DW-1:0]  div_quo;

	logic [1:0]       nxt_axis;
	logic [SUM_W-1:0] axis_sum;
	logic             axis_neg;
	logic [31:0]      h_next;
	logic             key_hit;
	logic             cnt_full;
	logic [COUNT_BITS-1:0] cdiv;
	vox_t             new_vox;
	vox_t             upd_vox;
	logic [UW:0]      rp_inc;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// shared multiplier operands: keys first, then hash terms
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_KEY) begin
			mul_b = $signed({4'b0, inv_q});
			case (step_q)
				2'd0:    mul_a = 33'(cmd_q.px);
				2'd1:    mul_a = 33'(cmd_q.py);
				default: mul_a = 33'(cmd_q.pz);
			endcase
		end else begin
			case (step_q)
				2'd0: begin
					mul_a = $signed({9'b0, kx_q});
					mul_b = HASH_KX;
				end
				2'd1: begin
					mul_a = $signed({9'b0, ky_q});
					mul_b = HASH_KY;
				end
				default: begin
					mul_a = $signed({9'b0, kz_q});
					mul_b = HASH_KZ;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign h_next = h_q ^ prod_s1[31:0];

	// divider operand selection
	assign nxt_axis = (state_q == S_RWT) ? 2'd0 : axis_q + 2'd1;
	assign cdiv     = (vrd_q.cnt == '0) ? COUNT_BITS'(1) : vrd_q.cnt;

	always_comb begin
		case (nxt_axis)
			2'd0:    axis_sum = vrd_q.sx;
			2'd1:    axis_sum = vrd_q.sy;
			2'd2:    axis_sum = vrd_q.sz;
			default: axis_sum = SUM_W'(vrd_q.iacc);
		endcase
	end

	assign axis_neg = (nxt_axis != 2'd3) && axis_sum[SUM_W-1];

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = DVW'(cdiv);
		if ((state_q == S_RWT && !mode_q) ||
			(state_q == S_DIV && div_done && axis_q != 2'd3)) begin
			div_start = 1'b1;
			div_dvd   = axis_neg ? (-axis_sum) : axis_sum;
		end
	end

	vgd_div #(
		.DW (DW),
		.DVW(DVW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.dvd   (div_dvd),
		.dvs   (div_dvs),
		.done  (div_done),
		.quo   (div_quo)
	);

	// entry contents for allocate and merge
	assign key_hit  = (vrd_q.kx == kx_q) && (vrd_q.ky == ky_q) && (vrd_q.kz == kz_q);
	assign cnt_full = &vrd_q.cnt;

	always_comb begin
		new_vox.kx    = kx_q;
		new_vox.ky    = ky_q;
		new_vox.kz    = kz_q;
		new_vox.sx    = SUM_W'(cmd_q.px);
		new_vox.sy    = SUM_W'(cmd_q.py);
		new_vox.sz    = SUM_W'(cmd_q.pz);
		new_vox.iacc  = ISUM_W'(cmd_q.intensity_in);
		new_vox.stamp = cmd_q.stamp_in;
		new_vox.cnt   = COUNT_BITS'(1);

		upd_vox     = vrd_q;
		upd_vox.cnt = vrd_q.cnt + 1'b1;
		if (!mode_q) begin
			upd_vox.sx   = vrd_q.sx + SUM_W'(cmd_q.px);
			upd_vox.sy   = vrd_q.sy + SUM_W'(cmd_q.py);
			upd_vox.sz   = vrd_q.sz + SUM_W'(cmd_q.pz);
			upd_vox.iacc = vrd_q.iacc + ISUM_W'(cmd_q.intensity_in);
		end else if (cmd_q.stamp_in > vrd_q.stamp) begin
			upd_vox.sx    = new_vox.sx;
			upd_vox.sy    = new_vox.sy;
			upd_vox.sz    = new_vox.sz;
			upd_vox.iacc  = new_vox.iacc;
			upd_vox.stamp = cmd_q.stamp_in;
		end
	end

	always_comb begin
		h_we = 1'b0;
		h_wa = slot_q;
		h_wd = '0;
		v_we = 1'b0;
		v_wa = vidx_q;
		v_wd = upd_vox;
		v_re = 1'b0;
		v_ra = hrd_q.idx;
		case (state_q)
			S_CLR: begin
				h_we = 1'b1;
				h_wa = clr_q;
			end
			S_PHV: v_re = hrd_q.vld;
			S_ADD: begin
				if (!found_q) begin
					if (empty_q && used_q < UW'(MAX_VOXELS)) begin
						h_we = 1'b1;
						h_wd = '{vld: 1'b1, idx: used_q[VI_W-1:0]};
						v_we = 1'b1;
						v_wa = used_q[VI_W-1:0];
						v_wd = new_vox;
					end
				end else if (!cnt_full) begin
					v_we = 1'b1;
				end
			end
			S_RRD: begin
				v_re = 1'b1;
				v_ra = rp_q[VI_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) hash_mem[h_wa] <= h_wd;
		if (state_q == S_PRD) hrd_q <= hash_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (v_we) vox_mem[v_wa] <= v_wd;
		if (v_re) vrd_q <= vox_mem[v_ra];
	end

	assign rp_inc = {1'b0, rp_q} + 1'b1;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			step_q  <= '0;
			inv_q   <= INV_RESET;
			mode_q  <= 1'b0;
			used_q  <= '0;
			rp_q    <= '0;
			clr_q   <= '0;
			probe_q <= '0;
			axis_q  <= '0;
			found_q <= 1'b0;
			empty_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INV:  inv_q  <= cfg_data;
					CFG_MODE: mode_q <= cfg_data[0];
					default:  ;
				endcase
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HS_W'(HASH_SLOTS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						step_q <= '0;
						if (cmd.action == ACT_ADD) begin
							state_q <= S_KEY;
						end else if (used_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RRD;
						end
					end
				end
				S_KEY: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						step_q  <= '0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						probe_q <= '0;
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PHV;
				S_PHV: begin
					if (!hrd_q.vld) begin
						found_q <= 1'b0;
						empty_q <= 1'b1;
						state_q <= S_ADD;
					end else begin
						state_q <= S_PVK;
					end
				end
				S_PVK: begin
					if (key_hit) begin
						found_q <= 1'b1;
						state_q <= S_ADD;
					end else if ({1'b0, probe_q} + 1'b1 == (PW + 1)'(HASH_SLOTS)) begin
						found_q <= 1'b0;
						empty_q <= 1'b0;
						state_q <= S_ADD;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_ADD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (!found_q && empty_q && used_q < UW'(MAX_VOXELS))
						used_q <= used_q + 1'b1;
				end
				S_RRD: state_q <= S_RWT;
				S_RWT: begin
					axis_q  <= '0;
					state_q <= mode_q ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (axis_q == 2'd3) state_q <= S_OUT;
						else axis_q <= axis_q + 1'b1;
					end
				end
				S_OUT: begin
					done_q <= 1'b1;
					if (rp_inc >= {1'b0, used_q}) begin
						rp_q    <= '0;
						used_q  <= '0;
						clr_q   <= '0;
						state_q <= S_CLR;
					end else begin
						rp_q    <= rp_inc[UW-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	logic axis_neg_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) cmd_q <= cmd;
		if (state_q == S_KEY) begin
			case (step_q)
				2'd1:    kx_q <= prod_s1[55:32];
				2'd2:    ky_q <= prod_s1[55:32];
				2'd3:    kz_q <= prod_s1[55:32];
				default: ;
			endcase
			h_q <= '0;
		end
		if (state_q == S_HASH && step_q != 2'd0) h_q <= h_next;
		// slot is the hash modulo a power-of-two table size
		if (state_q == S_HASH && step_q == 2'd3) slot_q <= h_next[HS_W-1:0];
		if (state_q == S_PHV) vidx_q <= hrd_q.idx;
		if (state_q == S_PVK && !key_hit)
			slot_q <= (slot_q == HS_W'(HASH_SLOTS - 1)) ? '0 : slot_q + 1'b1;
		if (div_start) axis_neg_q <= axis_neg;
		if (state_q == S_DIV && div_done) begin
			case (axis_q)
				2'd0:    rx_q <= axis_neg_q ? -div_quo[31:0] : div_quo[31:0];
				2'd1:    ry_q <= axis_neg_q ? -div_quo[31:0] : div_quo[31:0];
				2'd2:    rz_q <= axis_neg_q ? -div_quo[31:0] : div_quo[31:0];
				default: ri_q <= div_quo[15:0];
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start)
			rsp_q <= '{status: ST_EMPTY, default: '0};
		if (state_q == S_ADD) begin
			if (found_q) rsp_q <= '{status: ST_MERGED, default: '0};
			else if (empty_q && used_q < UW'(MAX_VOXELS))
				rsp_q <= '{status: ST_NEW, default: '0};
			else rsp_q <= '{status: ST_DROP, default: '0};
		end
		if (state_q == S_OUT) begin
			rsp_q.status <= ST_RESULT;
			rsp_q.last   <= (rp_inc >= {1'b0, used_q});
			if (mode_q) begin
				rsp_q.qx            <= vrd_q.sx[31:0];
				rsp_q.qy            <= vrd_q.sy[31:0];
				rsp_q.qz            <= vrd_q.sz[31:0];
				rsp_q.intensity_out <= vrd_q.iacc[15:0];
				rsp_q.stamp_out     <= vrd_q.stamp;
			end else begin
				rsp_q.qx            <= rx_q;
				rsp_q.qy            <= ry_q;
				rsp_q.qz            <= rz_q;
				rsp_q.intensity_out <= ri_q;
				rsp_q.stamp_out     <= '0;
			end
		end
	end

endmodule

@@ hdl/vgd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module vgd_div #(
	parameter int DW  = 48,
	parameter int DVW = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dvd,
	input  logic [DVW-1:0] dvs,
	output logic           done,
	output logic [DW-1:0]  quo
);
	localparam int CW = $clog2(DW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [DW-1:0]  quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [DVW:0]   trial;
	logic [DVW:0]   diff;
	logic           ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
